>>> rtl/ole_pkg.sv
`default_nettype none

package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMD_W    = 3;
    localparam int HANDLE_W = 32;
    localparam int STAT_W   = 2;
    localparam int OUT_CNT_W = 5;
    // common width for comparing the position field against the count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef logic [HANDLE_W-1:0] handle_t;

    typedef struct packed {
        logic             commit;
        logic             sample;
        logic [1:0]       op;
        logic [IDX_W-1:0] pos;
        handle_t          handle;
    } ole_ctrl_t;

    function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ole_cell.sv
`default_nettype none

module ole_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [ole_pkg::IDX_W-1:0] index,
    input  wire ole_pkg::ole_ctrl_t       ctrl,
    input  wire ole_pkg::handle_t         lower,
    input  wire ole_pkg::handle_t         upper,
    output ole_pkg::handle_t              value,
    output logic                          match
);
    import ole_pkg::*;

    handle_t value_reg;
    handle_t value_next;
    logic    match_reg;

    // shift up above an insert point, shift down from a remove point
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.commit)
        begin
            case (ctrl.op)
                OP_INSERT:
                begin
                    if (index == ctrl.pos)
                    begin
                        value_next = ctrl.handle;
                    end
                    else if (index > ctrl.pos)
                    begin
                        value_next = lower;
                    end
                end
                OP_REMOVE:
                begin
                    if (index >= ctrl.pos)
                    begin
                        value_next = upper;
                    end
                end
                default:
                begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            if (ctrl.sample)
            begin
                match_reg <= (value_reg == ctrl.handle);
            end
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

>>> rtl/ordered_list_engine.sv
// Ordered list of up to CAPACITY handles kept in a row of cells, one entry per
// cell. Each command transaction has three steps: accept, a compare step in which
// every cell checks its entry against the handle in parallel, and a commit step
// in which the cells at and above the operation point shift or load at once and
// the result is registered. in_ready is high only while the sequencer is idle,
// so a new command is taken only once the previous one has committed. The result
// register lets a new command be accepted while the previous result waits; the
// commit of that command holds until the waiting result is taken. Failed
// commands leave the list unchanged. Reset clears all entries and the count at once.
`default_nettype none

module ordered_list_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ole_pkg::CMD_W-1:0]    command,
    input  wire logic [ole_pkg::POS_W-1:0]    position,
    input  wire logic [ole_pkg::HANDLE_W-1:0] handle_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ole_pkg::HANDLE_W-1:0]      handle_out,
    output logic [ole_pkg::OUT_CNT_W-1:0]     entry_count,
    output logic [ole_pkg::STAT_W-1:0]        status
);
    import ole_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    handle_t           handle_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic                 out_valid_reg;
    handle_t              handle_out_reg;
    logic [OUT_CNT_W-1:0] count_out_reg;
    logic [STAT_W-1:0]    status_reg;

    handle_t           cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY-1:0] held_mask;
    ole_ctrl_t         ctrl;

    logic              accept;
    logic              exec_go;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  cnt_next_x;
    logic              full;
    logic [CAPACITY-1:0] hit;
    logic              found;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  rd_idx;
    handle_t           rd_value;
    logic [1:0]        op;
    logic [IDX_W-1:0]  op_pos;
    handle_t           result;
    logic [STAT_W-1:0] stat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // hold the commit while the previous result is still waiting
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // only entries below the count take part in a delete search
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            held_mask[i] = (CNT_W'(i) < count_reg);
        end
    end

    assign hit     = cell_match & held_mask;
    assign found   = |hit;
    assign hit_idx = first_set(hit);

    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(CAPACITY));

    assign rd_idx   = (cmd_reg == CMD_DELETE) ? hit_idx : pos_x[IDX_W-1:0];
    assign rd_value = cell_value[rd_idx];

    // decode the command into one broadcast operation for the cell row
    always_comb
    begin
        op         = OP_HOLD;
        op_pos     = pos_x[IDX_W-1:0];
        result     = '0;
        stat       = ST_OK;
        count_next = count_reg;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (full)
                begin
                    stat = ST_FULL;
                end
                else
                begin
                    op         = OP_INSERT;
                    op_pos     = cnt_x[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (full)
                begin
                    stat = ST_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    stat = ST_RANGE;
                end
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_x >= cnt_x)
                begin
                    stat = ST_RANGE;
                end
                else
                begin
                    op         = OP_REMOVE;
                    result     = rd_value;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (!found)
                begin
                    stat = ST_MISSING;
                end
                else
                begin
                    op         = OP_REMOVE;
                    op_pos     = hit_idx;
                    result     = rd_value;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_GET:
            begin
                if (pos_x >= cnt_x)
                begin
                    stat = ST_RANGE;
                end
                else
                begin
                    result = rd_value;
                end
            end
            default:
            begin
                op = OP_HOLD;
            end
        endcase
    end

    assign cnt_next_x = CMP_W'(count_next);

    assign ctrl.commit = exec_go;
    assign ctrl.sample = (state_reg == S_MATCH);
    assign ctrl.op     = op;
    assign ctrl.pos    = op_pos;
    assign ctrl.handle = handle_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        handle_t lower_val;
        handle_t upper_val;
        if (g == 0)
        begin : g_first
            assign lower_val = '0;
        end
        else
        begin : g_mid_lo
            assign lower_val = cell_value[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_val = '0;
        end
        else
        begin : g_mid_hi
            assign upper_val = cell_value[g+1];
        end
        ole_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .index (IDX_W'(g)),
            .ctrl  (ctrl),
            .lower (lower_val),
            .upper (upper_val),
            .value (cell_value[g]),
            .match (cell_match[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: capture the command on accept, the result on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            pos_reg    <= position;
            handle_reg <= handle_in;
        end
        if (exec_go)
        begin
            handle_out_reg <= result;
            count_out_reg  <= cnt_next_x[OUT_CNT_W-1:0];
            status_reg     <= stat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign handle_out  = handle_out_reg;
    assign entry_count = count_out_reg;
    assign status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_value[CAPACITY-1] != '0) |-> full)
        else $error("top cell holds data while list not full");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MATCH))
        else $error("accepted command did not enter compare cycle");

    a_match_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |=> (state_reg == S_EXEC))
        else $error("compare cycle not followed by commit");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("commit did not present a result");

endmodule

`default_nettype wire
